FILE: design/crs_pkg.sv
package crs_pkg;

    localparam int COORD_W = 32;
    localparam int T_FRAC  = 16;
    localparam int COEF_W  = COORD_W + 4;
    localparam int ACC_W   = COORD_W + 8;
    localparam int DIV_W   = 5;

    localparam int DIV_RESET  = 8;
    localparam int STEP_RESET = 8192;

    localparam logic CFG_DIVISIONS = 1'b0;
    localparam logic CFG_T_STEP    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [T_FRAC-1:0]         tfrac_t;
    typedef logic [DIV_W-1:0]          div_t;

endpackage

FILE: design/crs_point_if.sv
interface crs_point_if;
    logic              valid;
    logic              ready;
    crs_pkg::coord_t   point_x;
    crs_pkg::coord_t   point_y;
    crs_pkg::coord_t   point_z;
    logic              final_point;

    modport source (output valid, point_x, point_y, point_z, final_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

FILE: design/crs_sample_if.sv
interface crs_sample_if;
    logic              valid;
    logic              ready;
    crs_pkg::coord_t   curve_x;
    crs_pkg::coord_t   curve_y;
    crs_pkg::coord_t   curve_z;
    logic              run_end;
    logic              curve_end;

    modport source (output valid, curve_x, curve_y, curve_z, run_end, curve_end,
                    input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, run_end, curve_end,
                    output ready);
endinterface

FILE: design/catmull_rom_curve_subdivider.sv
// Catmull-Rom curve subdivider. Control points (signed Q16.16 x, y, z) come in on
// points; each one releases the samples of the segment that it completes, and the
// point flagged final_point also releases the closing segment and itself, with
// curve_end set. run_end marks the last sample caused by a point. One shared
// 36x17 multiplier does all the work: a segment first sets up the coefficients
// of each coordinate, then each sample forms t^2 and t^3, multiply-accumulates
// the v, b and a terms for each coordinate and hands the word to the output
// register. points is not ready while a point is being worked; a finished
// sample waits in the output register.
module catmull_rom_curve_subdivider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [crs_pkg::T_FRAC-1:0] cfg_data,
    crs_point_if.sink                  points,
    crs_sample_if.source               samples
);

    localparam int CW = crs_pkg::COORD_W;
    localparam int KW = crs_pkg::COEF_W;
    localparam int AW = crs_pkg::ACC_W;
    localparam int TF = crs_pkg::T_FRAC;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXT    = 3'd1;
    localparam logic [2:0] ST_COEF   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_PUT    = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    localparam logic [2:0] M_T2 = 3'd0;
    localparam logic [2:0] M_T3 = 3'd1;
    localparam logic [2:0] M_V  = 3'd2;
    localparam logic [2:0] M_B  = 3'd3;
    localparam logic [2:0] M_A  = 3'd4;

    function automatic crs_pkg::coord_t sat(input logic signed [AW-1:0] v);
        logic hi_or;
        logic hi_and;
        hi_or  = |v[AW-1:CW-1];
        hi_and = &v[AW-1:CW-1];
        if (!hi_or || hi_and)
            return v[CW-1:0];
        else if (v[AW-1])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    // p + floor((p - q) / 2), saturated
    function automatic crs_pkg::coord_t extrap(input crs_pkg::coord_t p,
                                               input crs_pkg::coord_t q);
        logic signed [CW:0]   d;
        logic signed [AW-1:0] s;
        d = {p[CW-1], p} - {q[CW-1], q};
        s = AW'(p) + AW'($signed(d[CW:1]));
        return sat(s);
    endfunction

    function automatic logic signed [KW-1:0] sx(input crs_pkg::coord_t v);
        return KW'(v);
    endfunction

    logic [2:0]          state_reg;
    crs_pkg::div_t       div_reg;
    crs_pkg::tfrac_t     step_reg;

    crs_pkg::coord_t     w0_reg [3];
    crs_pkg::coord_t     w1_reg [3];
    crs_pkg::coord_t     w2_reg [3];
    crs_pkg::coord_t     s_reg  [3];
    crs_pkg::coord_t     e_reg  [3];
    crs_pkg::coord_t     q_reg  [3];
    logic [1:0]          ps_reg;
    logic                fin_reg;
    logic                seg_final_reg;

    logic [1:0]          c_reg;
    logic                ph_reg;
    logic [2:0]          m_reg;
    crs_pkg::div_t       j_reg;
    crs_pkg::tfrac_t     t_reg;
    crs_pkg::tfrac_t     t2_reg;
    crs_pkg::tfrac_t     t3_reg;

    crs_pkg::coord_t         v0_reg [3];
    crs_pkg::coord_t         v1_reg;
    crs_pkg::coord_t         p1_reg [3];
    logic signed [KW-1:0]    a_reg  [3];
    logic signed [KW-1:0]    b_reg  [3];
    logic signed [AW-1:0]    acc_reg;
    crs_pkg::coord_t         stage_reg [3];

    logic                out_valid_reg;
    crs_pkg::coord_t     out_x_reg;
    crs_pkg::coord_t     out_y_reg;
    crs_pkg::coord_t     out_z_reg;
    logic                out_run_reg;
    logic                out_curve_reg;

    crs_pkg::coord_t     in_q [3];
    crs_pkg::coord_t     cp0, cp1, cp2, cp3;
    logic signed [CW:0]  d0, d1;
    crs_pkg::coord_t     v0_new, v1_new;
    logic signed [KW-1:0] a_new, b_new;
    logic signed [KW-1:0] mul_a;
    crs_pkg::tfrac_t     mul_b;
    logic signed [KW+TF:0] prod;
    logic signed [KW:0]  frac_term;
    logic signed [AW-1:0] term_ext;
    logic signed [AW-1:0] acc_sum;
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                last_sample;

    assign accept   = points.valid && points.ready;
    assign out_free = !out_valid_reg || samples.ready;
    assign out_load = ((state_reg == ST_EMIT) || (state_reg == ST_PUT)) && out_free;
    assign points.ready = (state_reg == ST_IDLE);

    assign in_q[0] = points.point_x;
    assign in_q[1] = points.point_y;
    assign in_q[2] = points.point_z;

    // segment neighbors for the coordinate under setup
    always_comb
    begin
        if (!seg_final_reg)
        begin
            cp0 = (ps_reg == 2'd2) ? s_reg[c_reg] : w0_reg[c_reg];
            cp1 = w1_reg[c_reg];
            cp2 = w2_reg[c_reg];
            cp3 = q_reg[c_reg];
        end
        else
        begin
            cp0 = (ps_reg == 2'd1) ? s_reg[c_reg] : w1_reg[c_reg];
            cp1 = w2_reg[c_reg];
            cp2 = q_reg[c_reg];
            cp3 = e_reg[c_reg];
        end
    end

    assign d0     = {cp2[CW-1], cp2} - {cp0[CW-1], cp0};
    assign d1     = {cp3[CW-1], cp3} - {cp1[CW-1], cp1};
    assign v0_new = d0[CW:1];
    assign v1_new = d1[CW:1];
    assign a_new  = (sx(cp1) <<< 1) - (sx(cp2) <<< 1) + sx(v0_reg[c_reg]) + sx(v1_reg);
    assign b_new  = ((sx(cp2) - sx(cp1)) <<< 1) + (sx(cp2) - sx(cp1))
                    - (sx(v0_reg[c_reg]) <<< 1) - sx(v1_reg);

    always_comb
    begin
        case (m_reg)
            M_T2:
            begin
                mul_a = KW'(t_reg);
                mul_b = t_reg;
            end
            M_T3:
            begin
                mul_a = KW'(t2_reg);
                mul_b = t_reg;
            end
            M_V:
            begin
                mul_a = sx(v0_reg[c_reg]);
                mul_b = t_reg;
            end
            M_B:
            begin
                mul_a = b_reg[c_reg];
                mul_b = t2_reg;
            end
            default:
            begin
                mul_a = a_reg[c_reg];
                mul_b = t3_reg;
            end
        endcase
    end

    assign prod      = (KW+TF+1)'(mul_a) * (KW+TF+1)'($signed({1'b0, mul_b}));
    assign frac_term = prod[KW+TF:TF];
    assign term_ext  = AW'(frac_term);
    assign acc_sum   = acc_reg + term_ext;
    assign last_sample = (j_reg == div_reg - crs_pkg::div_t'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_reg       <= crs_pkg::div_t'(crs_pkg::DIV_RESET);
            step_reg      <= crs_pkg::tfrac_t'(crs_pkg::STEP_RESET);
            ps_reg        <= 2'd0;
            fin_reg       <= 1'b0;
            seg_final_reg <= 1'b0;
            c_reg         <= 2'd0;
            ph_reg        <= 1'b0;
            m_reg         <= M_T2;
            j_reg         <= '0;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                w0_reg[i] <= '0;
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
                s_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == crs_pkg::CFG_DIVISIONS)
                    div_reg <= cfg_data[crs_pkg::DIV_W-1:0];
                else
                    step_reg <= cfg_data;
            end

            if (out_valid_reg && samples.ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        for (int i = 0; i < 3; i++)
                            q_reg[i] <= in_q[i];
                        fin_reg   <= points.final_point;
                        state_reg <= ST_EXT;
                    end
                end
                ST_EXT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e_reg[i] <= extrap(q_reg[i], w2_reg[i]);
                        if (ps_reg == 2'd1)
                            s_reg[i] <= extrap(w2_reg[i], q_reg[i]);
                    end
                    c_reg  <= 2'd0;
                    ph_reg <= 1'b0;
                    if (ps_reg[1])
                    begin
                        seg_final_reg <= 1'b0;
                        state_reg     <= ST_COEF;
                    end
                    else if (fin_reg && ps_reg == 2'd1)
                    begin
                        seg_final_reg <= 1'b1;
                        state_reg     <= ST_COEF;
                    end
                    else if (fin_reg)
                        state_reg <= ST_PUT;
                    else
                        state_reg <= ST_COMMIT;
                end
                ST_COEF:
                begin
                    if (!ph_reg)
                    begin
                        v0_reg[c_reg] <= v0_new;
                        v1_reg        <= v1_new;
                        ph_reg        <= 1'b1;
                    end
                    else
                    begin
                        a_reg[c_reg]  <= a_new;
                        b_reg[c_reg]  <= b_new;
                        p1_reg[c_reg] <= cp1;
                        ph_reg        <= 1'b0;
                        if (c_reg == 2'd2)
                        begin
                            c_reg <= 2'd0;
                            m_reg <= M_T2;
                            j_reg <= '0;
                            t_reg <= '0;
                            if (div_reg != '0)
                                state_reg <= ST_MUL;
                            else if (!seg_final_reg && fin_reg)
                            begin
                                seg_final_reg <= 1'b1;
                                state_reg     <= ST_COEF;
                            end
                            else if (fin_reg)
                                state_reg <= ST_PUT;
                            else
                                state_reg <= ST_COMMIT;
                        end
                        else
                            c_reg <= c_reg + 2'd1;
                    end
                end
                ST_MUL:
                begin
                    case (m_reg)
                        M_T2:
                        begin
                            t2_reg <= prod[2*TF-1:TF];
                            m_reg  <= M_T3;
                        end
                        M_T3:
                        begin
                            t3_reg <= prod[2*TF-1:TF];
                            m_reg  <= M_V;
                        end
                        M_V:
                        begin
                            acc_reg <= AW'(p1_reg[c_reg]) + term_ext;
                            m_reg   <= M_B;
                        end
                        M_B:
                        begin
                            acc_reg <= acc_sum;
                            m_reg   <= M_A;
                        end
                        default:
                        begin
                            stage_reg[c_reg] <= sat(acc_sum);
                            m_reg            <= M_V;
                            if (c_reg == 2'd2)
                            begin
                                c_reg     <= 2'd0;
                                state_reg <= ST_EMIT;
                            end
                            else
                                c_reg <= c_reg + 2'd1;
                        end
                    endcase
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= stage_reg[0];
                        out_y_reg     <= stage_reg[1];
                        out_z_reg     <= stage_reg[2];
                        out_run_reg   <= !fin_reg && last_sample;
                        out_curve_reg <= 1'b0;
                        t_reg         <= t_reg + step_reg;
                        j_reg         <= j_reg + crs_pkg::div_t'(1);
                        m_reg         <= M_T2;
                        if (!last_sample)
                            state_reg <= ST_MUL;
                        else if (!seg_final_reg && fin_reg)
                        begin
                            seg_final_reg <= 1'b1;
                            ph_reg        <= 1'b0;
                            state_reg     <= ST_COEF;
                        end
                        else if (fin_reg)
                            state_reg <= ST_PUT;
                        else
                            state_reg <= ST_COMMIT;
                    end
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= q_reg[0];
                        out_y_reg     <= q_reg[1];
                        out_z_reg     <= q_reg[2];
                        out_run_reg   <= 1'b1;
                        out_curve_reg <= 1'b1;
                        ps_reg        <= 2'd0;
                        for (int i = 0; i < 3; i++)
                        begin
                            w0_reg[i] <= '0;
                            w1_reg[i] <= '0;
                            w2_reg[i] <= '0;
                            s_reg[i]  <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_COMMIT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        w0_reg[i] <= w1_reg[i];
                        w1_reg[i] <= w2_reg[i];
                        w2_reg[i] <= q_reg[i];
                    end
                    if (ps_reg != 2'd3)
                        ps_reg <= ps_reg + 2'd1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign samples.valid     = out_valid_reg;
    assign samples.curve_x   = out_x_reg;
    assign samples.curve_y   = out_y_reg;
    assign samples.curve_z   = out_z_reg;
    assign samples.run_end   = out_run_reg;
    assign samples.curve_end = out_curve_reg;

    a_curve_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.curve_end |-> samples.run_end)
        else $error("curve_end without run_end");

    a_sample_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_EMIT) |-> (j_reg < div_reg))
        else $error("sample counter ran past divisions");

    a_coord_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COEF || state_reg == ST_MUL) |-> (c_reg != 2'd3))
        else $error("coordinate index out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) && out_valid_reg && !samples.ready |=> (state_reg == ST_PUT))
        else $error("closing point left before output drained");

endmodule

FILE: tb/catmull_rom_curve_subdivider_tb.sv
module catmull_rom_curve_subdivider_tb;

    typedef longint vec3_t [3];

    typedef struct {
        crs_pkg::coord_t x;
        crs_pkg::coord_t y;
        crs_pkg::coord_t z;
        logic   run_end;
        logic   curve_end;
    } sample_t;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    class curve_scoreboard;
        sample_t  pending_q[$];
        int       errors;
        longint   window [3][3];
        longint   start_pt [3];
        int       seen;
        int       divs;
        longint   step;

        function new();
            errors = 0;
            divs = crs_pkg::DIV_RESET;
            step = crs_pkg::STEP_RESET;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < 3; i++)
            begin
                start_pt[i] = 0;
                for (int c = 0; c < 3; c++)
                    window[i][c] = 0;
            end
            seen = 0;
        endfunction

        function longint sat(longint v);
            if (v > CMAX)
                return CMAX;
            if (v < CMIN)
                return CMIN;
            return v;
        endfunction

        function vec3_t extrap(vec3_t p, vec3_t q);
            vec3_t r;
            for (int c = 0; c < 3; c++)
                r[c] = sat(p[c] + ((p[c] - q[c]) >>> 1));
            return r;
        endfunction

        function void push(vec3_t p, logic last);
            sample_t s;
            s.x = crs_pkg::coord_t'(p[0]);
            s.y = crs_pkg::coord_t'(p[1]);
            s.z = crs_pkg::coord_t'(p[2]);
            s.run_end = 1'b0;
            s.curve_end = last;
            pending_q.push_back(s);
        endfunction

        function void segment(vec3_t p0, vec3_t p1, vec3_t p2, vec3_t p3);
            longint v0 [3];
            longint ca [3];
            longint cb [3];
            longint v1;
            longint t;
            longint t2;
            longint t3;
            vec3_t  y;
            for (int c = 0; c < 3; c++)
            begin
                v1 = (p3[c] - p1[c]) >>> 1;
                v0[c] = (p2[c] - p0[c]) >>> 1;
                ca[c] = 2 * p1[c] - 2 * p2[c] + v0[c] + v1;
                cb[c] = -3 * p1[c] + 3 * p2[c] - 2 * v0[c] - v1;
            end
            t = 0;
            for (int j = 0; j < divs; j++)
            begin
                t2 = (t * t) >> crs_pkg::T_FRAC;
                t3 = (t2 * t) >> crs_pkg::T_FRAC;
                for (int c = 0; c < 3; c++)
                    y[c] = sat(((ca[c] * t3) >>> crs_pkg::T_FRAC)
                               + ((cb[c] * t2) >>> crs_pkg::T_FRAC)
                               + ((v0[c] * t) >>> crs_pkg::T_FRAC) + p1[c]);
                push(y, 1'b0);
                t = (t + step) & 64'hffff;
            end
        endfunction

        function void note_point(crs_pkg::coord_t px, crs_pkg::coord_t py,
                                 crs_pkg::coord_t pz, logic fin);
            vec3_t q;
            vec3_t w0;
            vec3_t w1;
            vec3_t w2;
            vec3_t e;
            int    prior_count;
            prior_count = pending_q.size();
            q[0] = px;
            q[1] = py;
            q[2] = pz;
            for (int c = 0; c < 3; c++)
            begin
                w0[c] = window[0][c];
                w1[c] = window[1][c];
                w2[c] = window[2][c];
            end
            if (seen == 1)
                start_pt = extrap(w2, q);
            if (seen == 2)
                segment(start_pt, w1, w2, q);
            else if (seen == 3)
                segment(w0, w1, w2, q);
            if (fin)
            begin
                if (seen == 1)
                begin
                    e = extrap(q, w2);
                    segment(start_pt, w2, q, e);
                end
                else if (seen >= 2)
                begin
                    e = extrap(q, w2);
                    segment(w1, w2, q, e);
                end
                push(q, 1'b1);
                clear();
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                begin
                    window[0][c] = window[1][c];
                    window[1][c] = window[2][c];
                    window[2][c] = q[c];
                end
                if (seen < 3)
                    seen++;
            end
            if (pending_q.size() > prior_count)
                pending_q[pending_q.size() - 1].run_end = 1'b1;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_sample(sample_t got);
            sample_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected sample");
                return;
            end
            want = pending_q.pop_front();
            if (got.x !== want.x)
                report($sformatf("curve_x %h want %h", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("curve_y %h want %h", got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("curve_z %h want %h", got.z, want.z));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %b want %b", got.run_end, want.run_end));
            if (got.curve_end !== want.curve_end)
                report($sformatf("curve_end %b want %b", got.curve_end, want.curve_end));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [crs_pkg::T_FRAC-1:0] cfg_data;

    crs_point_if  pts ();
    crs_sample_if smp ();

    catmull_rom_curve_subdivider u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (pts),
        .samples   (smp)
    );

    curve_scoreboard sb;
    bit calm;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task write_reg(logic idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[crs_pkg::T_FRAC-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == crs_pkg::CFG_DIVISIONS)
            sb.divs = val & 31;
        else
            sb.step = val & 65535;
    endtask

    task send_point(crs_pkg::coord_t px, crs_pkg::coord_t py, crs_pkg::coord_t pz,
                    logic fin);
        int gap;
        pts.valid <= 1'b1;
        pts.point_x <= px;
        pts.point_y <= py;
        pts.point_z <= pz;
        pts.final_point <= fin;
        do
            @(posedge clk);
        while (!pts.ready);
        sb.note_point(px, py, pz, fin);
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            pts.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until all samples are out, then let a silent point finish
    task drain();
        @(posedge clk);
        pts.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    function crs_pkg::coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return crs_pkg::coord_t'($urandom);
            default: return crs_pkg::coord_t'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    task send_curve(int len);
        for (int i = 0; i < len; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
    endtask

    // sample side: accept, then stall a random number of cycles
    initial
    begin
        int stall;
        sample_t s;
        smp.ready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (smp.valid && smp.ready)
            begin
                s.x = smp.curve_x;
                s.y = smp.curve_y;
                s.z = smp.curve_z;
                s.run_end = smp.run_end;
                s.curve_end = smp.curve_end;
                sb.check_sample(s);
                stall = calm ? 0 : $urandom_range(0, 10);
            end
            else if (stall > 0)
                stall--;
            smp.ready <= (stall == 0);
        end
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = crs_pkg::CFG_DIVISIONS;
        cfg_data = '0;
        pts.valid = 1'b0;
        pts.point_x = '0;
        pts.point_y = '0;
        pts.point_z = '0;
        pts.final_point = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone point, two-point curve, saturating ends, longer curve
        send_point(32'h7fffffff, 32'h80000000, 32'h00010000, 1'b1);
        send_point(32'h00000000, 32'h00010000, 32'hffff0000, 1'b0);
        send_point(32'h00050000, 32'hfffb0000, 32'h00020000, 1'b1);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_point(32'h7fffffff, 32'h80000000, 32'h00000000, 1'b1);
        send_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0);
        send_point(32'h7fffffff, 32'h80000000, 32'h00000001, 1'b1);
        drain();
        write_reg(crs_pkg::CFG_DIVISIONS, 31);
        write_reg(crs_pkg::CFG_T_STEP, 2114);
        send_curve(5);
        drain();
        write_reg(crs_pkg::CFG_DIVISIONS, 0);
        write_reg(crs_pkg::CFG_T_STEP, 1);
        send_curve(4);
        send_curve(1);
        drain();
        write_reg(crs_pkg::CFG_DIVISIONS, 1);
        write_reg(crs_pkg::CFG_T_STEP, 65535);
        send_curve(3);
        drain();
        write_reg(crs_pkg::CFG_DIVISIONS, 3);
        write_reg(crs_pkg::CFG_T_STEP, 40000);
        send_curve(4);
        drain();

        sent = 0;
        while (sent < 100)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(crs_pkg::CFG_DIVISIONS, ($urandom_range(0, 7) == 0)
                          ? $urandom_range(0, 31) : $urandom_range(1, 6));
                write_reg(crs_pkg::CFG_T_STEP, ($urandom_range(0, 3) == 0)
                          ? $urandom_range(0, 65535) : 65536 / (sb.divs + 1));
            end
            calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 3; k++)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 8);
                send_curve(len);
                sent += len;
            end
            drain();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: catmull_rom_curve_subdivider.f
design/crs_pkg.sv
design/crs_point_if.sv
design/crs_sample_if.sv
design/catmull_rom_curve_subdivider.sv
tb/catmull_rom_curve_subdivider_tb.sv
